/* rtl/core/bda_pkg.sv */
// Shared constants, types and helpers for the button debounce / auto-repeat block.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none

package bda_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int LEVEL_W     = 8;
    localparam int INDEX_W     = 3;
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_INTVL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_MASK  = 3'd4;

    // Reset values of the tick registers
    localparam logic [TICK_W-1:0] DEBOUNCE_RST  = 16'd64;
    localparam logic [TICK_W-1:0] RPT_DELAY_RST = 16'd750;
    localparam logic [TICK_W-1:0] RPT_INTVL_RST = 16'd256;

    typedef logic [1:0]         t_phase;
    typedef logic [LEVEL_W-1:0] t_levels;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [TICK_W-1:0]  t_ticks;

    localparam t_phase PH_IDLE     = 2'd0;
    localparam t_phase PH_DEBOUNCE = 2'd1;
    localparam t_phase PH_REPEAT   = 2'd2;

    // A programmed wait of zero counts as one tick.
    function automatic t_ticks wait_len(input t_ticks v);
        wait_len = (v == '0) ? t_ticks'(1) : v;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bda_in_if.sv */
// Tick channel: valid/ready plus the sampled button levels.
// Depends on bda_pkg.
`default_nettype none

interface bda_in_if
    import bda_pkg::*;
;
    logic    valid;
    logic    ready;
    t_levels button_levels;

    modport source (output valid, output button_levels, input ready);
    modport sink   (input valid, input button_levels, output ready);
endinterface

`default_nettype wire

/* rtl/core/bda_out_if.sv */
// Report channel: valid/ready plus the reported button index.
// Depends on bda_pkg.
`default_nettype none

interface bda_out_if
    import bda_pkg::*;
;
    logic   valid;
    logic   ready;
    t_index button_index;

    modport source (output valid, output button_index, input ready);
    modport sink   (input valid, input button_index, output ready);
endinterface

`default_nettype wire

/* rtl/core/button_debounce_autorepeat_unit.sv */
// Top level of the button debounce / auto-repeat block.
// Depends on bda_pkg, bda_in_if and bda_out_if.
//
//   channel   dir  payload                  meaning
//   i_btn     in   button_levels [7:0]      one request per millisecond tick
//   o_key     out  button_index  [2:0]      zero or one report per tick
//   i_cfg_*   in   idx [2:0], data [15:0]   register writes, no back-pressure
//
// Two stages: the tick request is captured in an input register; the state
// step (priority pick, countdown compare/decrement) runs from it and loads the
// report register once that register is free or draining. One tick is
// accepted per cycle while o_key does not stall. The input register refills
// whenever the report register is empty or being drained, so stalls on o_key
// back up at most one tick behind the pending report. Reset (sync, active low)
// empties both stages and returns all config registers to their defaults.
`default_nettype none

module button_debounce_autorepeat_unit
    import bda_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bda_in_if.sink                     i_btn,
    bda_out_if.source                  o_key,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    logic               r_enable;
    t_ticks             r_debounce;
    t_ticks             r_rpt_delay;
    t_ticks             r_rpt_intvl;
    logic [LEVEL_W-1:0] r_rpt_mask;

    // block state
    t_phase r_phase,     n_phase;
    t_index r_held,      n_held;
    t_ticks r_countdown, n_countdown;

    // input stage
    logic    r_in_vld;
    t_levels r_levels;

    // report stage
    logic   r_out_vld, n_report;
    t_index r_out_idx;

    logic   advance;
    logic   any_pressed;
    t_index pick;
    logic   held_pressed;

    // step when a tick is held and the report slot is free or draining
    assign advance     = r_in_vld && (!r_out_vld || o_key.ready);
    assign i_btn.ready = !r_in_vld || advance;

    assign o_key.valid        = r_out_vld;
    assign o_key.button_index = r_out_idx;

    // lowest-numbered pressed button among the scanned ones
    always_comb begin
        any_pressed = 1'b0;
        pick        = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (i < LEVEL_W && r_levels[i]) begin
                any_pressed = 1'b1;
                pick        = t_index'(i);
            end
        end
    end

    assign held_pressed = r_levels[r_held];

    // one tick of the debounce / repeat state machine
    always_comb begin
        n_phase     = r_phase;
        n_held      = r_held;
        n_countdown = r_countdown;
        n_report    = 1'b0;
        if (!r_enable) begin
            n_phase     = PH_IDLE;
            n_held      = '0;
            n_countdown = '0;
        end else if (r_phase != PH_DEBOUNCE && r_phase != PH_REPEAT) begin
            // idle scan (unused phase code acts as idle)
            if (any_pressed) begin
                n_phase     = PH_DEBOUNCE;
                n_held      = pick;
                n_countdown = wait_len(r_debounce);
                n_report    = 1'b1;
            end else begin
                n_phase     = PH_IDLE;
                n_held      = '0;
                n_countdown = '0;
            end
        end else if (r_countdown > t_ticks'(1)) begin
            n_countdown = r_countdown - t_ticks'(1);
        end else if (!held_pressed) begin
            // released at the end of the wait
            n_phase     = PH_IDLE;
            n_held      = '0;
            n_countdown = '0;
        end else if (r_phase == PH_DEBOUNCE) begin
            if (r_rpt_mask[r_held]) begin
                n_phase     = PH_REPEAT;
                n_countdown = wait_len(r_rpt_delay);
            end else begin
                n_countdown = wait_len(r_debounce);
            end
        end else begin
            n_countdown = wait_len(r_rpt_intvl);
            n_report    = 1'b1;
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_phase     <= PH_IDLE;
            r_held      <= '0;
            r_countdown <= '0;
            r_enable    <= 1'b0;
            r_debounce  <= DEBOUNCE_RST;
            r_rpt_delay <= RPT_DELAY_RST;
            r_rpt_intvl <= RPT_INTVL_RST;
            r_rpt_mask  <= '0;
        end else begin
            if (i_btn.ready) begin
                r_in_vld <= i_btn.valid;
            end
            if (advance) begin
                r_out_vld   <= n_report;
                r_phase     <= n_phase;
                r_held      <= n_held;
                r_countdown <= n_countdown;
            end else if (o_key.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_phase     <= PH_IDLE;
                            r_held      <= '0;
                            r_countdown <= '0;
                        end
                    end
                    CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[TICK_W-1:0];
                    CFG_RPT_DELAY: r_rpt_delay <= i_cfg_data[TICK_W-1:0];
                    CFG_RPT_INTVL: r_rpt_intvl <= i_cfg_data[TICK_W-1:0];
                    CFG_RPT_MASK:  r_rpt_mask  <= i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_btn.ready && i_btn.valid) begin
            r_levels <= i_btn.button_levels;
        end
        if (advance && n_report) begin
            r_out_idx <= n_held;
        end
    end

endmodule

`default_nettype wire
